/* hw/rtl/lsbr_pkg.sv */
// lsbr_pkg: shared types and constants of the LSB-first bit reader.
// Used by lsbr_mem and lsb_first_bit_reader; no dependencies.
`default_nettype none

package lsbr_pkg;

    localparam int BUFFER_BYTES_DEF = 4096;
    localparam int WORD_W           = 64;
    localparam int CURSOR_W         = 16;
    localparam int DBYTES_W         = 13;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DATA_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_LIMIT  = 1'b1;

    localparam logic [DBYTES_W-1:0] DATA_BYTES_RST = '0;
    localparam logic [CURSOR_W-1:0] BIT_LIMIT_RST  = 16'd32768;

    localparam logic [6:0] MAX_COUNT = 7'd64;

    typedef enum logic [2:0] {
        OP_WRITE    = 3'd0,
        OP_RD_U     = 3'd1,
        OP_RD_S     = 3'd2,
        OP_RD_BYTES = 3'd3,
        OP_REALIGN  = 3'd4,
        OP_SEEK     = 3'd5,
        OP_RESTART  = 3'd6,
        OP_NOP      = 3'd7
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_SHIFT,
        S_EMIT,
        S_BCHK,
        S_BRD,
        S_BOUT
    } t_state;

endpackage

`default_nettype wire

/* hw/rtl/lsbr_mem.sv */
// lsbr_mem: byte buffer held as 64-bit words, byte-lane write, registered read.
// Depends on lsbr_pkg.
`default_nettype none

module lsbr_mem
    import lsbr_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
    localparam int WORDS       = (BUFFER_BYTES + 7) / 8,
    localparam int AW          = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [AW-1:0]     i_wr_addr,
    input  wire logic [2:0]        i_wr_lane,
    input  wire logic [7:0]        i_wr_byte,
    input  wire logic [AW-1:0]     i_rd_addr,
    output logic      [WORD_W-1:0] o_rd_data
);

    logic [WORD_W-1:0] r_mem [WORDS];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr][{i_wr_lane, 3'b000} +: 8] <= i_wr_byte;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

/* hw/rtl/lsb_first_bit_reader.sv */
// lsb_first_bit_reader: top level of the LSB-first bit reader.
// Depends on lsbr_pkg and lsbr_mem.
//
// Input words are taken when i_in_valid is high and o_in_stall is low; result
// words (value, failed, last) leave through an output register and are taken
// when o_out_valid is high and i_out_stall is low. data_bytes (index 0) and
// bit_limit (index 1) are written on the cfg channel; the user must do so only
// while idle, the block does not enforce it. Write byte, realign, seek, restart
// and no-op complete on acceptance. A bit read reaches the output register via
// address, second word read, shift and sign extension; a failing one goes to
// emit. A byte read sets up, then reads a word per byte; a failing one emits.
// i_rst_n (synchronous) clears the cursor, the failure flag, the output valid bit
// and the config registers, not the buffer; input and cfg are held off during it.
// A stalled result holds in the output register. The next word is still taken,
// but its result waits, and the input stalls, until the register frees.
`default_nettype none

module lsb_first_bit_reader
    import lsbr_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [2:0]            i_opcode,
    input  wire logic [11:0]           i_byte_address,
    input  wire logic [7:0]            i_byte_value,
    input  wire logic [6:0]            i_count,
    input  wire logic [15:0]           i_seek_target,

    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [63:0]           o_value,
    output logic                       o_failed,
    output logic                       o_last,

    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int WORDS = (BUFFER_BYTES + 7) / 8;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

    t_state r_state, n_state;

    logic [DBYTES_W-1:0] r_data_bytes;
    logic [CURSOR_W-1:0] r_bit_limit;
    logic [CURSOR_W-1:0] r_cursor;
    logic                r_sticky;

    logic [2:0]          r_op;
    logic [6:0]          r_count;
    logic                r_fail;
    logic [9:0]          r_word;
    logic [5:0]          r_off;
    logic [WORD_W-1:0]   r_lo;
    logic [WORD_W-1:0]   r_field;
    logic [12:0]         r_bidx;
    logic [6:0]          r_left;

    logic                r_out_valid;
    logic [63:0]         r_out_value;
    logic                r_out_failed;
    logic                r_out_last;

    logic [WORD_W-1:0]   rd_data;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;

    logic                in_acc;
    logic                out_free;
    logic [DBYTES_W-1:0] nb;
    logic [CURSOR_W-1:0] lim;
    logic [CURSOR_W-1:0] rem;
    logic [CURSOR_W-1:0] realigned;
    logic                fail_rd;
    logic                fail_bytes;
    logic [WORD_W-1:0]   mask;
    logic                sign_bit;
    logic [63:0]         emit_value;
    logic [7:0]          out_byte;

    // effective limit, remaining bits and realigned cursor
    always_comb begin
        nb = ({4'b0, r_data_bytes} > 17'(BUFFER_BYTES)) ? DBYTES_W'(BUFFER_BYTES)
                                                         : r_data_bytes;
        lim = (r_bit_limit < {nb, 3'b000}) ? r_bit_limit : {nb, 3'b000};
        rem = (r_cursor < lim) ? (lim - r_cursor) : '0;
        realigned = (r_cursor + 16'd7) & ~16'd7;
    end

    assign in_acc   = (r_state == S_IDLE) && i_in_valid && i_rst_n;
    assign out_free = !r_out_valid || !i_out_stall;

    assign fail_rd    = (i_count > MAX_COUNT) || r_sticky || ({9'b0, i_count} > rem);
    assign fail_bytes = (r_count > MAX_COUNT) || r_sticky
                        || ({6'b0, r_count} > rem[15:3]);

    assign mask     = ~({WORD_W{1'b1}} << r_count);
    assign sign_bit = r_field[r_count[5:0] - 6'd1];
    assign out_byte = rd_data[{r_bidx[2:0], 3'b000} +: 8];

    always_comb begin
        if (r_fail) begin
            emit_value = '0;
        end else if (r_op == OP_RD_S && r_count != 7'd0 && r_count < MAX_COUNT
                     && sign_bit) begin
            emit_value = r_field | ~mask;
        end else begin
            emit_value = r_field;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_opcode == OP_RD_U || i_opcode == OP_RD_S) begin
                        n_state = fail_rd ? S_EMIT : S_RD1;
                    end else if (i_opcode == OP_RD_BYTES) begin
                        n_state = S_BCHK;
                    end
                end
            end
            S_RD1:   n_state = S_SHIFT;
            S_SHIFT: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_BCHK: begin
                if (fail_bytes) begin
                    n_state = S_EMIT;
                end else if (r_count == 7'd0) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_BRD;
                end
            end
            S_BRD:   n_state = S_BOUT;
            S_BOUT: begin
                if (out_free && r_left == 7'd1) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_state = S_BRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        rd_addr    = AW'(r_cursor[15:6]);
        wr_en      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = !i_rst_n;
                wr_en      = in_acc && (i_opcode == OP_WRITE)
                             && ({5'b0, i_byte_address} < 17'(BUFFER_BYTES));
            end
            S_RD1:   rd_addr = AW'(r_word + 10'd1);
            S_BRD:   rd_addr = AW'(r_bidx[12:3]);
            S_BOUT:  rd_addr = AW'(r_bidx[12:3]);
            default: rd_addr = AW'(r_cursor[15:6]);
        endcase
    end

    lsbr_mem #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(i_byte_address[11:3])),
        .i_wr_lane (i_byte_address[2:0]),
        .i_wr_byte (i_byte_value),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_data_bytes <= DATA_BYTES_RST;
            r_bit_limit  <= BIT_LIMIT_RST;
            r_cursor     <= '0;
            r_sticky     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_DATA_BYTES: r_data_bytes <= i_cfg_data[DBYTES_W-1:0];
                    CFG_BIT_LIMIT:  r_bit_limit  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (in_acc) begin
                case (i_opcode)
                    OP_RD_U, OP_RD_S: begin
                        if (fail_rd) begin
                            r_sticky <= 1'b1;
                        end else begin
                            r_cursor <= r_cursor + {9'b0, i_count};
                        end
                    end
                    OP_RD_BYTES, OP_REALIGN: r_cursor <= realigned;
                    OP_SEEK: begin
                        if (i_seek_target > lim) begin
                            r_sticky <= 1'b1;
                        end else begin
                            r_cursor <= i_seek_target;
                        end
                    end
                    OP_RESTART: begin
                        r_cursor <= '0;
                        r_sticky <= 1'b0;
                    end
                    default: ;
                endcase
            end

            if (r_state == S_BCHK) begin
                if (fail_bytes) begin
                    r_sticky <= 1'b1;
                end else begin
                    r_cursor <= r_cursor + {6'b0, r_count, 3'b000};
                end
            end

            if ((r_state == S_EMIT || r_state == S_BOUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= i_opcode;
            r_count <= i_count;
            r_fail  <= fail_rd;
            r_word  <= r_cursor[15:6];
            r_off   <= r_cursor[5:0];
        end
        if (r_state == S_RD1) begin
            r_lo <= rd_data;
        end
        if (r_state == S_SHIFT) begin
            r_field <= WORD_W'({rd_data, r_lo} >> r_off) & mask;
        end
        if (r_state == S_BCHK) begin
            r_fail <= fail_bytes;
            r_bidx <= r_cursor[15:3];
            r_left <= r_count;
        end
        if (r_state == S_EMIT && out_free) begin
            r_out_value  <= emit_value;
            r_out_failed <= r_fail;
            r_out_last   <= 1'b1;
        end
        if (r_state == S_BOUT && out_free) begin
            r_out_value  <= {56'b0, out_byte};
            r_out_failed <= 1'b0;
            r_out_last   <= (r_left == 7'd1);
            r_bidx       <= r_bidx + 13'd1;
            r_left       <= r_left - 7'd1;
        end
    end

    assign o_cfg_ready = i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_failed    = r_out_failed;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire
